@@ rtl/core/psb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package psb_pkg;

    localparam int unsigned PALETTE_ENTRIES_DEF = 256;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned CH_W   = 8;
    localparam int unsigned PROD_W = 17;
    localparam int unsigned CFG_AW = 3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_SHADE_ENABLE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SHADE_RED    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SHADE_GREEN  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SHADE_BLUE   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SEMI_TRANS   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_BLEND_SELECT = 3'd5;

    localparam logic [1:0] BLEND_HALF_ADD    = 2'd0;
    localparam logic [1:0] BLEND_ADD         = 2'd1;
    localparam logic [1:0] BLEND_SUBTRACT    = 2'd2;
    localparam logic [1:0] BLEND_QUARTER_ADD = 2'd3;

    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [CH_W-1:0] ALPHA_HALF   = 8'd128;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CH_W-1:0] SHADE_NEUTRAL = 8'd128;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_rgba;

    typedef struct packed {
        logic            shade_enable;
        logic [CH_W-1:0] shade_red;
        logic [CH_W-1:0] shade_green;
        logic [CH_W-1:0] shade_blue;
        logic            semi_transparent;
        logic [1:0]      blend_select;
    } t_cfg;

    // min(255, floor(x / 255)) for x = 2*c*s, no divider
    function automatic logic [CH_W-1:0] div255_sat(input logic [PROD_W-1:0] x);
        logic [15:0] x16;
        logic [16:0] sum;
        logic [7:0]  q1;
        logic [15:0] back;
        logic [15:0] rem;
        x16  = x[15:0];
        sum  = {1'b0, x16} + {9'd0, x16[15:8]};
        q1   = sum[15:8];
        back = {q1, 8'd0} - {8'd0, q1};
        rem  = x16 - back;
        if (x >= 17'd65025) begin
            div255_sat = 8'd255;
        end else if (rem >= 16'd255) begin
            div255_sat = q1 + 8'd1;
        end else begin
            div255_sat = q1;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/psb_palette.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psb_palette #(
    parameter int unsigned PALETTE_ENTRIES = psb_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [psb_pkg::IDX_W-1:0] i_wr_idx,
    input  wire psb_pkg::t_rgba           i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [psb_pkg::IDX_W-1:0] i_rd_idx,
    output psb_pkg::t_rgba                o_rd_data
);

    localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    psb_pkg::t_rgba r_mem [PALETTE_ENTRIES];
    psb_pkg::t_rgba r_q;
    logic           r_hit;

    logic wr_hit;
    logic rd_hit;

    assign wr_hit = {1'b0, i_wr_idx} < (psb_pkg::IDX_W+1)'(PALETTE_ENTRIES);
    assign rd_hit = {1'b0, i_rd_idx} < (psb_pkg::IDX_W+1)'(PALETTE_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_hit) begin
            r_mem[i_wr_idx[AW-1:0]] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q   <= r_mem[i_rd_idx[AW-1:0]];
            r_hit <= rd_hit;
        end
    end

    // out-of-range index reads as an all-zero entry
    assign o_rd_data = r_hit ? r_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/palette_shade_blend_pixel_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                   payload
// s (in)    in   i_s_tvalid / o_s_tready     tdata: index, red, green, blue, alpha; tuser: action
// m (out)   out  o_m_tvalid / i_m_tready     tdata: red, green, blue, alpha
// cfg       in   i_cfg_valid / o_cfg_ready   i_cfg_addr register index, i_cfg_wdata value
//
// one item per clock while the output is not stalled; a pixel shows on o_m_tvalid once it has passed
// the registered palette read, the shade multiply stage and the result register
// palette writes give no result and free their slot at once
// reset clears the valid bits and sets the configuration registers to their defaults, the palette is not cleared
// a stalled output only blocks input once all three stages hold items

module palette_shade_blend_pixel_core #(
    parameter int unsigned PALETTE_ENTRIES = psb_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // pixel_index, entry_red, entry_green, entry_blue, entry_alpha
    input  wire logic        i_s_tuser,   // action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // out_red, out_green, out_blue, out_alpha
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [psb_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata
);

    psb_pkg::t_cfg  r_cfg;
    psb_pkg::t_rgba in_entry;
    psb_pkg::t_rgba rd_entry;
    logic [psb_pkg::IDX_W-1:0] in_idx;

    logic s_acc, out_en, b_en, a_en;
    logic r_a_v, r_b_v, r_out_v;

    psb_pkg::t_rgba r_b_col;
    logic           r_b_zero;
    logic [psb_pkg::PROD_W-1:0] r_b_pr, r_b_pg, r_b_pb;
    psb_pkg::t_rgba r_out;
    psb_pkg::t_rgba n_out;

    logic [psb_pkg::CH_W-1:0] sh_r, sh_g, sh_b;
    logic [15:0] prod_r, prod_g, prod_b;

    assign in_idx         = i_s_tdata[7:0];
    assign in_entry.red   = i_s_tdata[15:8];
    assign in_entry.green = i_s_tdata[23:16];
    assign in_entry.blue  = i_s_tdata[31:24];
    assign in_entry.alpha = i_s_tdata[39:32];

    // each stage moves when the next one is empty or moving
    assign out_en     = !r_out_v || i_m_tready;
    assign b_en       = !r_b_v || out_en;
    assign a_en       = !r_a_v || b_en;
    assign o_s_tready = a_en;
    assign s_acc      = i_s_tvalid && a_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shade_enable     <= 1'b0;
            r_cfg.shade_red        <= psb_pkg::SHADE_NEUTRAL;
            r_cfg.shade_green      <= psb_pkg::SHADE_NEUTRAL;
            r_cfg.shade_blue       <= psb_pkg::SHADE_NEUTRAL;
            r_cfg.semi_transparent <= 1'b0;
            r_cfg.blend_select     <= psb_pkg::BLEND_HALF_ADD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                psb_pkg::REG_SHADE_ENABLE: r_cfg.shade_enable     <= i_cfg_wdata[0];
                psb_pkg::REG_SHADE_RED:    r_cfg.shade_red        <= i_cfg_wdata;
                psb_pkg::REG_SHADE_GREEN:  r_cfg.shade_green      <= i_cfg_wdata;
                psb_pkg::REG_SHADE_BLUE:   r_cfg.shade_blue       <= i_cfg_wdata;
                psb_pkg::REG_SEMI_TRANS:   r_cfg.semi_transparent <= i_cfg_wdata[0];
                psb_pkg::REG_BLEND_SELECT: r_cfg.blend_select     <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    psb_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (s_acc && !i_s_tuser),
        .i_wr_idx  (in_idx),
        .i_wr_data (in_entry),
        .i_rd_en   (s_acc && i_s_tuser),
        .i_rd_idx  (in_idx),
        .o_rd_data (rd_entry)
    );

    assign prod_r = {8'd0, rd_entry.red}   * {8'd0, r_cfg.shade_red};
    assign prod_g = {8'd0, rd_entry.green} * {8'd0, r_cfg.shade_green};
    assign prod_b = {8'd0, rd_entry.blue}  * {8'd0, r_cfg.shade_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (a_en) begin
                r_a_v <= s_acc && i_s_tuser;
            end
            if (b_en) begin
                r_b_v <= r_a_v;
            end
            if (out_en) begin
                r_out_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b_col  <= rd_entry;
            r_b_zero <= (rd_entry == '0);
            r_b_pr   <= {prod_r, 1'b0};
            r_b_pg   <= {prod_g, 1'b0};
            r_b_pb   <= {prod_b, 1'b0};
        end
        if (out_en) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        if (r_cfg.shade_enable) begin
            sh_r = psb_pkg::div255_sat(r_b_pr);
            sh_g = psb_pkg::div255_sat(r_b_pg);
            sh_b = psb_pkg::div255_sat(r_b_pb);
        end else begin
            sh_r = r_b_col.red;
            sh_g = r_b_col.green;
            sh_b = r_b_col.blue;
        end
        n_out.red   = sh_r >> 1;
        n_out.green = sh_g >> 1;
        n_out.blue  = sh_b >> 1;
        n_out.alpha = psb_pkg::ALPHA_CLEAR;
        priority if (r_b_zero) begin
            n_out.red   = '0;
            n_out.green = '0;
            n_out.blue  = '0;
            n_out.alpha = psb_pkg::ALPHA_OPAQUE;
        end else if (r_cfg.semi_transparent && r_b_col.alpha == psb_pkg::ALPHA_OPAQUE) begin
            unique case (r_cfg.blend_select)
                psb_pkg::BLEND_HALF_ADD: begin
                    n_out.alpha = psb_pkg::ALPHA_HALF;
                end
                psb_pkg::BLEND_QUARTER_ADD: begin
                    n_out.red   = sh_r >> 2;
                    n_out.green = sh_g >> 2;
                    n_out.blue  = sh_b >> 2;
                    n_out.alpha = psb_pkg::ALPHA_OPAQUE;
                end
                psb_pkg::BLEND_ADD, psb_pkg::BLEND_SUBTRACT: begin
                    n_out.red   = sh_r;
                    n_out.green = sh_g;
                    n_out.blue  = sh_b;
                    n_out.alpha = psb_pkg::ALPHA_OPAQUE;
                end
                default: ;
            endcase
        end else begin
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out.alpha, r_out.blue, r_out.green, r_out.red};

    // only pixel items take a slot in the pipe
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_a_v == $past(i_s_tuser)))
        else $error("stage a slot does not follow accepted action");

    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && out_en) |=> r_out_v)
        else $error("item lost between shade stage and output");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.alpha == psb_pkg::ALPHA_CLEAR
                  || r_out.alpha == psb_pkg::ALPHA_HALF
                  || r_out.alpha == psb_pkg::ALPHA_OPAQUE))
        else $error("result alpha outside its three codes");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> o_s_tready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire
